// ===== design/plbl_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// plbl_pkg
// Shared types and constants of the per-peer token bucket limiter: table size,
// fixed-point token format, slot layout, verdict and operation codes.
// -----------------------------------------------------------------------------
package plbl_pkg;

	// table and token format
	localparam int PEER_SLOTS          = 16;
	localparam int TOKEN_FRACTION_BITS = 16;
	localparam int INT_BITS            = 8;
	localparam int LEVEL_W             = INT_BITS + TOKEN_FRACTION_BITS;
	localparam int SLOT_W              = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

	// field widths
	localparam int INDEX_W    = 8;
	localparam int GEN_W      = 32;
	localparam int TIME_W     = 48;
	localparam int BURST_W    = 8;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_CNT_W  = $clog2(LEVEL_W + 1);

	// operation codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BURST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REFILL = CFG_IDX_W'(1);

	// configuration reset values
	localparam logic [BURST_W-1:0]    BURST_RESET    = BURST_W'(5);
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

	// verdict codes
	typedef enum logic [1:0] {
		VERDICT_GRANTED = 2'd0,
		VERDICT_EMPTY   = 2'd1,
		VERDICT_BAD_IDX = 2'd2,
		VERDICT_CLEARED = 2'd3
	} verdict_t;

	// one table slot
	typedef struct packed {
		logic [GEN_W-1:0]   gen;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  last;
	} slot_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [LEVEL_W-1:0] quot;
	} div_stat_t;

endpackage

// ===== design/per_peer_token_bucket_limiter_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// per_peer_token_bucket_limiter_top
// Per-peer token bucket rate limiter with a slot table and shared divider.
// -----------------------------------------------------------------------------
// One word at a time: in_ready is high only while the sequencer is idle. A
// clear or a refused peer index goes from accept straight to the output step.
// A rate check reads its slot from the table RAM, works out elapsed time
// and, when a partial refill is due, runs the shared bit-serial divider over
// all LEVEL_W quotient bits (Q8.16 tokens by default); then come the apply
// and output steps, and the divider is skipped when the refill saturates.
// Slot validity lives in flip-flops, so reset and clear take effect at once
// with no sweep of the table.
// -----------------------------------------------------------------------------
module per_peer_token_bucket_limiter_top import plbl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [INDEX_W-1:0]    peer_index,
	input  logic [GEN_W-1:0]      peer_generation,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  allowed,
	output logic [1:0]            verdict
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t                state_q;
	logic [BURST_W-1:0]    burst_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [PEER_SLOTS-1:0] slot_vld_q;

	logic [SLOT_W-1:0]     idx_q;
	logic [GEN_W-1:0]      gen_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [LEVEL_W:0]      level_q;
	logic                  res_allowed_q;
	verdict_t              res_verdict_q;
	logic                  out_valid_q;
	logic                  allowed_q;
	verdict_t              verdict_q;

	logic                  accept;
	logic                  bad_idx;
	logic [LEVEL_W-1:0]    full;
	slot_t                 rd_slot;
	slot_t                 cur_slot;
	slot_t                 wr_slot;
	logic                  rekey;
	logic [LEVEL_W-1:0]    start_level;
	logic [TIME_W-1:0]     start_last;
	logic                  saturate;
	logic                  div_start;
	div_stat_t             div_stat;
	logic [LEVEL_W-1:0]    clamped;
	logic                  grant;
	logic                  slot_we;
	logic                  out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign bad_idx  = {1'b0, peer_index} >= (INDEX_W + 1)'(PEER_SLOTS);
	assign full     = {burst_q, {TOKEN_FRACTION_BITS{1'b0}}};
	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q    <= BURST_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BURST) begin
				burst_q <= cfg_wdata[BURST_W-1:0];
			end else if (cfg_index == REG_REFILL) begin
				interval_q <= cfg_wdata;
			end
		end
	end

	// slot table
	plbl_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (PEER_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (idx_q),
		.wdata (wr_slot),
		.raddr (peer_index[SLOT_W-1:0]),
		.rdata (rd_slot)
	);

	// owner check and elapsed time, an invalid slot reads as all zero
	always_comb begin
		cur_slot = slot_vld_q[idx_q] ? rd_slot : slot_t'('0);
		if (slot_vld_q[idx_q]) begin
			rekey = cur_slot.gen != gen_q;
		end else begin
			rekey = (idx_q != SLOT_W'(0)) || (gen_q != GEN_W'(0));
		end
		start_level = rekey ? full : cur_slot.level;
		start_last  = rekey ? now_q : cur_slot.last;
	end

	// refill saturates when a zero interval or 256 or more whole tokens are due
	assign saturate  = (interval_q == INTERVAL_W'(0)) ||
	                   (elapsed_q >= TIME_W'({interval_q, {INT_BITS{1'b0}}}));
	assign div_start = (state_q == ST_PREP) && !saturate;

	plbl_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.rem_init    (elapsed_q[INT_BITS +: INTERVAL_W]),
		.dividend_lo ({elapsed_q[INT_BITS-1:0], {TOKEN_FRACTION_BITS{1'b0}}}),
		.divisor     (interval_q),
		.stat        (div_stat)
	);

	// clamp and spend
	always_comb begin
		clamped       = (level_q > {1'b0, full}) ? full : level_q[LEVEL_W-1:0];
		grant         = clamped >= (LEVEL_W)'(1 << TOKEN_FRACTION_BITS);
		wr_slot.gen   = gen_q;
		wr_slot.level = grant ? LEVEL_W'(clamped - LEVEL_W'(1 << TOKEN_FRACTION_BITS))
		                      : clamped;
		wr_slot.last  = now_q;
		slot_we       = (state_q == ST_APPLY);
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_CLEAR) begin
							slot_vld_q <= '0;
							state_q    <= ST_FIN;
						end else if (bad_idx) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= saturate ? ST_APPLY : ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					slot_vld_q[idx_q] <= 1'b1;
					state_q           <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q <= peer_index[SLOT_W-1:0];
				gen_q <= peer_generation;
				now_q <= now_ms;
				res_allowed_q <= 1'b0;
				if (operation == OP_CLEAR) begin
					res_verdict_q <= VERDICT_CLEARED;
				end else begin
					res_verdict_q <= VERDICT_BAD_IDX;
				end
			end
			ST_READ: begin
				level_q   <= {1'b0, start_level};
				elapsed_q <= (now_q >= start_last) ? TIME_W'(now_q - start_last) : '0;
			end
			ST_PREP: begin
				if (saturate) begin
					level_q <= {1'b0, full};
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					level_q <= level_q + {1'b0, div_stat.quot};
				end
			end
			ST_APPLY: begin
				res_allowed_q <= grant;
				res_verdict_q <= grant ? VERDICT_GRANTED : VERDICT_EMPTY;
			end
			ST_FIN: begin
				if (out_free) begin
					allowed_q <= res_allowed_q;
					verdict_q <= res_verdict_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign allowed   = allowed_q;
	assign verdict   = verdict_q;

	// a clear empties the whole table before the next word
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_CLEAR) |=> (slot_vld_q == '0))
		else $error("clear left a slot valid");

	// allowed is set exactly for a granted verdict
	a_allowed_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (allowed == (verdict == VERDICT_GRANTED)))
		else $error("allowed disagrees with verdict");

	// the divider is never running while a new word can be taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while idle");

	// a table write marks its slot valid
	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |=> slot_vld_q[$past(idx_q)])
		else $error("slot write did not mark the slot valid");

endmodule

// ===== design/plbl_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// plbl_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module plbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/plbl_div.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// plbl_div
// Restoring radix-2 divider, one quotient bit per cycle. The caller hands in a
// partial remainder already below the divisor and the low dividend bits; the
// quotient is LEVEL_W bits wide.
// -----------------------------------------------------------------------------
module plbl_div import plbl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [INTERVAL_W-1:0] rem_init,
	input  logic [LEVEL_W-1:0]    dividend_lo,
	input  logic [INTERVAL_W-1:0] divisor,
	output div_stat_t             stat
);

	logic [INTERVAL_W-1:0] rem_q;
	logic [LEVEL_W-1:0]    work_q;
	logic [INTERVAL_W-1:0] div_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [INTERVAL_W:0]   shifted;
	logic                  ge;
	logic [INTERVAL_W-1:0] rem_next;

	// one trial subtraction per cycle
	always_comb begin
		shifted  = {rem_q, work_q[LEVEL_W-1]};
		ge       = shifted >= {1'b0, div_q};
		rem_next = ge ? INTERVAL_W'(shifted - {1'b0, div_q}) : shifted[INTERVAL_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			work_q <= dividend_lo;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			work_q <= {work_q[LEVEL_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = work_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-peer token bucket limiter. A queue of
// request words (directed corner cases, then random traffic over several
// burst/interval settings) feeds a valid/ready driver. A bucket predictor
// with its own slot table computes the verdict of every accepted word, and a
// monitor with random back-pressure compares each result word in order.
// -----------------------------------------------------------------------------
module tb_top import plbl_pkg::*; ();

	localparam int RANDOM_WORDS = 750;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int QUIET_LIMIT  = 4000;
	localparam int REPORT_CAP   = 100;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] idx;
		logic [GEN_W-1:0]   owner;
		logic [TIME_W-1:0]  stamp;
	} word_t;

	typedef struct packed {
		logic     allowed;
		verdict_t verdict;
	} verdict_rec_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
	logic                  in_valid        = 1'b0;
	logic                  operation       = OP_CHECK;
	logic [INDEX_W-1:0]    peer_index      = '0;
	logic [GEN_W-1:0]      peer_generation = '0;
	logic [TIME_W-1:0]     now_ms          = '0;
	logic                  out_ready       = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  allowed;
	logic [1:0]            verdict;

	// pending request words and expected verdicts
	word_t        word_q[$];
	verdict_rec_t verdict_q[$];

	// register mirror and bucket table of the predictor
	logic [BURST_W-1:0]    burst_mirror    = BURST_RESET;
	logic [INTERVAL_W-1:0] interval_mirror = INTERVAL_RESET;
	logic [INDEX_W-1:0]    own_idx   [PEER_SLOTS];
	logic [GEN_W-1:0]      own_gen   [PEER_SLOTS];
	logic [LEVEL_W-1:0]    tokens    [PEER_SLOTS];
	logic [TIME_W-1:0]     seen_ms   [PEER_SLOTS];

	// traffic generator state
	logic [TIME_W-1:0] sim_ms = '0;
	logic [GEN_W-1:0]  slot_owner_gen [PEER_SLOTS];

	int   error_count = 0;
	int   quiet_cycles = 0;
	int   wait_left = 0;
	int   stall_left = 0;
	int   stall_draw;
	bit   send_calm = 1'b0;
	bit   recv_calm = 1'b0;
	bit   hold_req = 1'b0;
	bit   hold_seen = 1'b0;
	word_t nxt;

	per_peer_token_bucket_limiter_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.peer_index      (peer_index),
		.peer_generation (peer_generation),
		.now_ms          (now_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.allowed         (allowed),
		.verdict         (verdict)
	);

	always #10 clk = ~clk;

	// bucket predictor: refill, clamp, spend one token
	function automatic void predict_verdict(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [GEN_W-1:0] owner, input logic [TIME_W-1:0] stamp);
		logic [63:0]  full;
		logic [63:0]  level;
		logic [63:0]  gap_ms;
		logic [63:0]  iv;
		logic [63:0]  q;
		logic [63:0]  r;
		verdict_rec_t rec;
		full = 64'(burst_mirror) << TOKEN_FRACTION_BITS;
		rec.allowed = 1'b0;
		if (op == OP_CLEAR) begin
			for (int s = 0; s < PEER_SLOTS; s++) begin
				own_idx[s] = '0;
				own_gen[s] = '0;
				tokens[s]  = '0;
				seen_ms[s] = '0;
			end
			rec.verdict = VERDICT_CLEARED;
		end else if (idx >= PEER_SLOTS) begin
			rec.verdict = VERDICT_BAD_IDX;
		end else begin
			// a different connection takes over the slot with a full bucket
			if (own_idx[idx] != idx || own_gen[idx] != owner) begin
				own_idx[idx] = idx;
				own_gen[idx] = owner;
				tokens[idx]  = full[LEVEL_W-1:0];
				seen_ms[idx] = stamp;
			end
			gap_ms = (stamp >= seen_ms[idx]) ? 64'(stamp - seen_ms[idx]) : 64'd0;
			seen_ms[idx] = stamp;
			level = 64'(tokens[idx]);
			if (interval_mirror == '0) begin
				level = full;
			end else if (gap_ms != 0) begin
				iv = 64'(interval_mirror);
				q  = gap_ms / iv;
				r  = gap_ms % iv;
				if (q >= 256)
					level = full;
				else
					level = level + (q << TOKEN_FRACTION_BITS)
						+ ((r << TOKEN_FRACTION_BITS) / iv);
			end
			if (level > full)
				level = full;
			if (level >= (64'd1 << TOKEN_FRACTION_BITS)) begin
				level = level - (64'd1 << TOKEN_FRACTION_BITS);
				rec.allowed = 1'b1;
				rec.verdict = VERDICT_GRANTED;
			end else begin
				rec.verdict = VERDICT_EMPTY;
			end
			tokens[idx] = level[LEVEL_W-1:0];
		end
		verdict_q.push_back(rec);
	endfunction

	task automatic report_mismatch(input string msg);
		// keep the log short when everything goes wrong
		if (error_count < REPORT_CAP)
			$display("tb: mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void push_word(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [GEN_W-1:0] owner, input logic [TIME_W-1:0] stamp);
		word_t w;
		w.op    = op;
		w.idx   = idx;
		w.owner = owner;
		w.stamp = stamp;
		word_q.push_back(w);
	endfunction

	// mostly well-formed traffic on live slots, some refused and clear words
	function automatic void add_random_word();
		int unsigned       pick;
		int unsigned       slot;
		int unsigned       iv;
		logic [TIME_W-1:0] step;
		pick = $urandom_range(0, 99);
		iv = (interval_mirror == '0) ? 1000 : interval_mirror;
		if (pick < 2) begin
			push_word(OP_CLEAR, INDEX_W'($urandom), $urandom, TIME_W'({$urandom, $urandom}));
		end else if (pick < 7) begin
			push_word(OP_CHECK, INDEX_W'($urandom_range(PEER_SLOTS, 255)), $urandom,
				TIME_W'({$urandom, $urandom}));
		end else if (pick < 9) begin
			// the identity a zeroed slot already holds
			push_word(OP_CHECK, '0, '0, sim_ms);
		end else begin
			slot = $urandom_range(0, PEER_SLOTS - 1);
			if ($urandom_range(0, 15) == 0)
				slot_owner_gen[slot] = $urandom;
			case ($urandom_range(0, 9))
				0: step = '0;
				1, 2, 3: step = TIME_W'($urandom_range(0, iv / 2 + 1));
				4, 5: step = TIME_W'($urandom_range(0, iv * 2));
				6: step = TIME_W'($urandom_range(0, iv * 8));
				7: step = TIME_W'($urandom_range(0, iv * 300));
				8: step = -TIME_W'($urandom_range(1, iv));
				default: step = TIME_W'({$urandom, $urandom}) - sim_ms;
			endcase
			sim_ms = sim_ms + step;
			push_word(OP_CHECK, INDEX_W'(slot), slot_owner_gen[slot], sim_ms);
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BURST)
			burst_mirror = BURST_W'(val);
		else
			interval_mirror = INTERVAL_W'(val);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (word_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: offers queued words, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			wait_left <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_verdict(operation, peer_index, peer_generation, now_ms);
			if ($urandom_range(0, 39) == 0)
				send_calm <= ~send_calm;
			if (in_valid && !in_ready) begin
				// hold the word until taken
			end else if (wait_left != 0) begin
				wait_left <= wait_left - 1;
				in_valid  <= 1'b0;
			end else if (word_q.size() != 0) begin
				nxt = word_q.pop_front();
				operation       <= nxt.op;
				peer_index      <= nxt.idx;
				peer_generation <= nxt.owner;
				now_ms          <= nxt.stamp;
				in_valid        <= 1'b1;
				wait_left       <= send_calm ? 0 : $urandom_range(0, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: random stalls, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word allowed=%0b verdict=%0d",
						allowed, verdict));
				end else if (allowed !== verdict_q[0].allowed
					|| verdict !== verdict_q[0].verdict) begin
					report_mismatch($sformatf("allowed=%0b verdict=%0d, want %0b/%0d",
						allowed, verdict, verdict_q[0].allowed, verdict_q[0].verdict));
				end
				if (verdict_q.size() != 0)
					void'(verdict_q.pop_front());
				if ($urandom_range(0, 39) == 0)
					recv_calm <= ~recv_calm;
			end
			if (hold_req && !hold_seen) begin
				hold_seen  <= 1'b1;
				stall_left <= HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else if (out_valid && out_ready) begin
				stall_draw = recv_calm ? 0 : $urandom_range(0, 19);
				stall_left <= stall_draw;
				out_ready  <= (stall_draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no word taken in and no register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned burst_plan [PHASES];
		int unsigned interval_plan [PHASES];
		burst_plan    = '{1, 255, 0, 8, 255, 1, 0, 0};
		interval_plan = '{1, 65535, 1000, 0, 1, 65535, 0, 0};
		burst_plan[6]    = $urandom_range(1, 255);
		burst_plan[7]    = $urandom_range(1, 255);
		interval_plan[6] = $urandom_range(1, 65535);
		interval_plan[7] = $urandom_range(1, 65535);
		for (int s = 0; s < PEER_SLOTS; s++) begin
			own_idx[s] = '0;
			own_gen[s] = '0;
			tokens[s]  = '0;
			seen_ms[s] = '0;
			slot_owner_gen[s] = $urandom;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zeroed slot, re-key, drain to empty, half refills,
		// backward time, huge gap, refused indexes, clear
		@(negedge clk);
		push_word(OP_CHECK, 8'd0, '0, 48'd0);
		push_word(OP_CHECK, 8'd0, '0, 48'd1000);
		repeat (6) push_word(OP_CHECK, 8'd3, 32'd7, 48'd1000);
		push_word(OP_CHECK, 8'd3, 32'd7, 48'd1500);
		push_word(OP_CHECK, 8'd3, 32'd7, 48'd2000);
		push_word(OP_CHECK, 8'd3, 32'd7, 48'd500);
		push_word(OP_CHECK, 8'd3, 32'd7, '1);
		push_word(OP_CHECK, 8'd16, 32'd7, 48'd3000);
		push_word(OP_CHECK, 8'hFF, '1, '1);
		push_word(OP_CHECK, 8'd15, '1, '1);
		push_word(OP_CLEAR, 8'hFF, '1, '1);
		push_word(OP_CHECK, 8'd3, 32'd7, '1);
		push_word(OP_CHECK, 8'd0, '0, 48'd5);
		push_word(OP_CHECK, 8'd0, '0, 48'h8000_0000_0000);
		wait_drained();

		// random traffic over burst/interval settings, extremes included
		sim_ms = 48'd10_000;
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_BURST, burst_plan[p]);
			write_reg(REG_REFILL, interval_plan[p]);
			@(negedge clk);
			if (p == 0)
				hold_req = 1'b1;
			repeat (RANDOM_WORDS / PHASES) add_random_word();
			wait_drained();
		end

		if (error_count == 0 && verdict_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
